// ===== rtl/fpms_pkg.sv =====
package fpms_pkg;

    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 13;
    localparam int QLEN_W  = 6;
    localparam int SCORE_W = 10;
    localparam int EPOS_W  = 9;
    localparam int BON_W   = 5;
    localparam int QREGS   = 4;
    localparam int CFG_AW  = 6;

    localparam logic [2:0] REG_QLEN = 3'd0;
    localparam logic [2:0] REG_QC0  = 3'd1;
    localparam logic [2:0] REG_QC1  = 3'd2;
    localparam logic [2:0] REG_QC2  = 3'd3;
    localparam logic [2:0] REG_QC3  = 3'd4;

    localparam logic [SCORE_W-1:0] FIRST_GAP_COST = 10'd9;
    localparam logic [SCORE_W-1:0] NEXT_GAP_COST  = 10'd1;
    localparam logic [BON_W-1:0]   BASE_BONUS     = 5'd10;
    localparam logic [BON_W-1:0]   SEP_FOLLOW     = 5'd2;
    localparam logic [BON_W-1:0]   SLASH_FOLLOW   = 5'd3;
    localparam logic [BON_W-1:0]   ON_SEP         = 5'd3;
    localparam logic [BON_W-1:0]   TAIL_PATH      = 5'd2;
    localparam logic [BON_W-1:0]   EXACT_UPPER    = 5'd3;

    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;

    typedef struct packed {
        logic              ovf;
        logic              slash_v;
        logic [LEN_W-1:0]  slash;
        logic [LEN_W-1:0]  len;
        logic [QLEN_W-1:0] q;
    } t_job;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_OUT
    } t_bstate;

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return c == 8'h2f || c == 8'h5f || c == 8'h2d || c == 8'h2e ||
               c == 8'h23 || c == 8'h5c || c == 8'h20;
    endfunction

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return c >= 8'h41 && c <= 8'h5a;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return is_upper(c) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return is_upper(c) ? c + 8'd32 : c;
    endfunction

endpackage

// ===== rtl/fpms_ram.sv =====
module fpms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/fpms_front.sv =====
module fpms_front #(
    parameter int MAX_STRING = 256,
    parameter int MAX_QUERY  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fpms_pkg::CHAR_W-1:0] i_text_char,
    input  logic                        i_last_char,
    input  logic [fpms_pkg::QLEN_W-1:0] i_qlen,
    output logic                        o_busy,
    output logic                        o_we,
    output logic [$clog2(MAX_STRING)-1:0] o_waddr,
    output logic [fpms_pkg::CHAR_W-1:0] o_wdata,
    output logic                        o_job_v,
    output fpms_pkg::t_job              o_job,
    input  logic                        i_pop,
    input  logic                        i_done
);
    import fpms_pkg::*;

    localparam int AW = $clog2(MAX_STRING);
    localparam int LW = $clog2(MAX_STRING + 1);

    logic          r_busy, r_jv, r_slash_v, r_ovf;
    logic [LW-1:0] r_len, r_slash;
    t_job          r_job;
    logic          acc, room;
    logic [LW-1:0] n_len;
    logic          n_slash_v, n_ovf;
    logic [LW-1:0] n_slash;
    logic [QLEN_W-1:0] qc;

    assign acc  = i_start && !r_busy;
    assign room = r_len < LW'(MAX_STRING);

    always_comb begin
        n_len     = r_len;
        n_slash   = r_slash;
        n_slash_v = r_slash_v;
        n_ovf     = r_ovf;
        if (room) begin
            n_len = r_len + 1'b1;
            if (i_text_char == CH_SLASH && r_len != '0) begin
                n_slash   = r_len;
                n_slash_v = 1'b1;
            end
        end else begin
            n_ovf = 1'b1;
        end
        qc = (i_qlen > QLEN_W'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY) : i_qlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_jv      <= 1'b0;
            r_len     <= '0;
            r_slash   <= '0;
            r_slash_v <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_pop) begin
                r_jv <= 1'b0;
            end
            if (i_done) begin
                r_busy <= 1'b0;
            end
            if (acc) begin
                if (i_last_char) begin
                    r_busy    <= 1'b1;
                    r_jv      <= 1'b1;
                    r_len     <= '0;
                    r_slash   <= '0;
                    r_slash_v <= 1'b0;
                    r_ovf     <= 1'b0;
                end else begin
                    r_len     <= n_len;
                    r_slash   <= n_slash;
                    r_slash_v <= n_slash_v;
                    r_ovf     <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_last_char) begin
            r_job.ovf     <= n_ovf;
            r_job.slash_v <= n_slash_v;
            r_job.slash   <= LEN_W'(n_slash);
            r_job.len     <= LEN_W'(n_len);
            r_job.q       <= qc;
        end
    end

    assign o_busy  = r_busy;
    assign o_we    = acc && room;
    assign o_waddr = r_len[AW-1:0];
    assign o_wdata = i_text_char;
    assign o_job_v = r_jv;
    assign o_job   = r_job;
endmodule

// ===== rtl/fpms_back.sv =====
module fpms_back #(
    parameter int MAX_STRING = 256,
    parameter int MAX_QUERY  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_v,
    input  fpms_pkg::t_job                i_job,
    output logic                          o_pop,
    input  logic [8*MAX_QUERY-1:0]        i_qchars,
    output logic [$clog2(MAX_STRING)-1:0] o_raddr,
    input  logic [fpms_pkg::CHAR_W-1:0]   i_rdata,
    output logic                          o_done,
    output logic [fpms_pkg::SCORE_W-1:0]  o_score,
    output logic [fpms_pkg::EPOS_W-1:0]   o_epos,
    output logic                          o_too_long
);
    import fpms_pkg::*;

    localparam int AW = $clog2(MAX_STRING);
    localparam int LW = $clog2(MAX_STRING + 1);
    localparam int QW = $clog2(MAX_QUERY + 1);

    t_bstate r_state, n_state;
    t_job    r_job;
    logic [LW-1:0] r_addr, r_pos, r_cpos, r_bpos;
    logic          r_dv, r_upd, r_bv;
    logic [CHAR_W-1:0]  r_prev;
    logic [SCORE_W-1:0] r_best;
    logic [SCORE_W-1:0] r_m [MAX_QUERY+1];
    logic [SCORE_W-1:0] r_g [MAX_QUERY+1];
    logic               r_mv [MAX_QUERY+1];
    logic               r_gv [MAX_QUERY+1];
    logic [SCORE_W-1:0] n_m [MAX_QUERY+1];
    logic [SCORE_W-1:0] n_g [MAX_QUERY+1];
    logic               n_mv [MAX_QUERY+1];
    logic               n_gv [MAX_QUERY+1];
    logic          issue, pop;
    logic [BON_W-1:0] bon;
    logic [QW-1:0] qi;
    logic [SCORE_W-1:0] cm;
    logic          cmv;

    assign qi  = r_job.q[QW-1:0];
    assign cm  = r_m[qi];
    assign cmv = r_mv[qi];

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_v) begin
                    n_state = (i_job.ovf || i_job.q == '0) ? B_OUT : B_RUN;
                end
            end
            B_RUN: begin
                if (!issue && !r_dv && !r_upd) begin
                    n_state = B_OUT;
                end
            end
            B_OUT:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        pop    = 1'b0;
        issue  = 1'b0;
        o_done = 1'b0;
        case (r_state)
            B_IDLE:  pop = i_job_v;
            B_RUN:   issue = r_addr < LW'(r_job.len);
            B_OUT:   o_done = 1'b1;
            default: pop = 1'b0;
        endcase
    end

    // position bonus
    always_comb begin
        if (r_pos == '0) begin
            bon = BASE_BONUS + SEP_FOLLOW;
        end else if (is_sep(r_prev) && is_letter(i_rdata)) begin
            bon = (r_prev == CH_SLASH) ? BASE_BONUS + SLASH_FOLLOW
                                       : BASE_BONUS + SEP_FOLLOW;
        end else begin
            bon = BASE_BONUS + (is_sep(i_rdata) ? ON_SEP : '0);
        end
        if (r_job.slash_v && r_pos > LW'(r_job.slash)) begin
            bon = bon + TAIL_PATH;
        end
    end

    // one cell per query column, all updated from the previous row
    always_comb begin
        logic [CHAR_W-1:0]  a;
        logic [SCORE_W-1:0] gs, ms, p, sc;
        n_m[0] = '0;  n_g[0] = '0;  n_mv[0] = 1'b1;  n_gv[0] = 1'b1;
        for (int j = 1; j <= MAX_QUERY; j++) begin
            a  = i_qchars[8*(j-1) +: 8];
            gs = (r_gv[j] && r_g[j] >= NEXT_GAP_COST) ? r_g[j] - NEXT_GAP_COST : '0;
            ms = (r_mv[j] && r_m[j] >= FIRST_GAP_COST) ? r_m[j] - FIRST_GAP_COST : '0;
            n_gv[j] = r_mv[j] || r_gv[j];
            n_g[j]  = (gs > ms) ? gs : ms;
            if (!r_mv[j-1]) begin
                p = r_g[j-1];
            end else if (!r_gv[j-1]) begin
                p = r_m[j-1];
            end else begin
                p = (r_m[j-1] > r_g[j-1]) ? r_m[j-1] : r_g[j-1];
            end
            sc = SCORE_W'(bon) +
                 ((is_upper(i_rdata) && a == i_rdata) ? SCORE_W'(EXACT_UPPER) : '0);
            n_mv[j] = (fold(a) == fold(i_rdata)) && (r_mv[j-1] || r_gv[j-1]);
            n_m[j]  = p + sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_dv    <= 1'b0;
            r_upd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= issue;
            r_upd   <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job  <= i_job;
            r_addr <= '0;
            r_pos  <= '0;
            r_bv   <= 1'b0;
            r_best <= '0;
            r_bpos <= '0;
            for (int j = 0; j <= MAX_QUERY; j++) begin
                r_m[j]  <= '0;
                r_g[j]  <= '0;
                r_mv[j] <= (j == 0);
                r_gv[j] <= (j == 0);
            end
        end else begin
            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_dv) begin
                r_prev <= i_rdata;
                r_pos  <= r_pos + 1'b1;
                r_cpos <= r_pos + 1'b1;
                for (int j = 0; j <= MAX_QUERY; j++) begin
                    r_m[j]  <= n_m[j];
                    r_g[j]  <= n_g[j];
                    r_mv[j] <= n_mv[j];
                    r_gv[j] <= n_gv[j];
                end
            end
            if (r_upd && cmv && (!r_bv || cm >= r_best)) begin
                r_bv   <= 1'b1;
                r_best <= cm;
                r_bpos <= r_cpos;
            end
        end
    end

    assign o_pop      = pop;
    assign o_raddr    = r_addr[AW-1:0];
    assign o_too_long = r_job.ovf;
    assign o_score    = r_job.ovf ? '0 : (r_job.q == '0) ? SCORE_W'(1) :
                        r_bv ? r_best : '0;
    assign o_epos     = (!r_job.ovf && r_job.q != '0 && r_bv) ? EPOS_W'(r_bpos) : '0;
endmodule

// ===== rtl/fuzzy_path_match_scorer.sv =====
// channel   signals                                         handshake
// config    psel penable pwrite paddr pwdata prdata pready  apb, 64-bit regs at 8*i
// request   i_text_char i_last_char                         start && !busy
// result    o_best_score o_end_position o_too_long          o_result_valid, 1 cycle
//
// one character per cycle to load while busy is low; after the last character busy stays
// high through the result cycle while the score pass reads the string ram once per character
// and updates all query cells when that character's read data returns
// reset is synchronous and clears control state, query registers and the load counters
// results cannot be stalled; a new string is taken the cycle after the result
module fuzzy_path_match_scorer #(
    parameter int MAX_STRING = 256,
    parameter int MAX_QUERY  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpms_pkg::CFG_AW-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [fpms_pkg::CHAR_W-1:0]  i_text_char,
    input  logic                         i_last_char,
    output logic                         o_result_valid,
    output logic [fpms_pkg::SCORE_W-1:0] o_best_score,
    output logic [fpms_pkg::EPOS_W-1:0]  o_end_position,
    output logic                         o_too_long
);
    import fpms_pkg::*;

    localparam int AW = $clog2(MAX_STRING);

    logic [QLEN_W-1:0] r_qlen;
    logic [63:0]       r_qc [QREGS];
    logic [2:0]        idx;
    logic [255:0]      qflat;
    logic              we, job_v, pop;
    logic [AW-1:0]     waddr, raddr;
    logic [CHAR_W-1:0] wdata, rdata;
    t_job              job;

    assign idx    = paddr[5:3];
    assign pready = 1'b1;
    assign qflat  = {r_qc[3], r_qc[2], r_qc[1], r_qc[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
            for (int i = 0; i < QREGS; i++) begin
                r_qc[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_QLEN: r_qlen  <= pwdata[QLEN_W-1:0];
                REG_QC0:  r_qc[0] <= pwdata;
                REG_QC1:  r_qc[1] <= pwdata;
                REG_QC2:  r_qc[2] <= pwdata;
                REG_QC3:  r_qc[3] <= pwdata;
                default:  r_qlen  <= r_qlen;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_QLEN: prdata = 64'(r_qlen);
            REG_QC0:  prdata = r_qc[0];
            REG_QC1:  prdata = r_qc[1];
            REG_QC2:  prdata = r_qc[2];
            REG_QC3:  prdata = r_qc[3];
            default:  prdata = '0;
        endcase
    end

    fpms_front #(.MAX_STRING(MAX_STRING), .MAX_QUERY(MAX_QUERY)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_text_char (i_text_char),
        .i_last_char (i_last_char),
        .i_qlen      (r_qlen),
        .o_busy      (busy),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_job_v     (job_v),
        .o_job       (job),
        .i_pop       (pop),
        .i_done      (o_result_valid)
    );

    fpms_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_STRING)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    fpms_back #(.MAX_STRING(MAX_STRING), .MAX_QUERY(MAX_QUERY)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_v    (job_v),
        .i_job      (job),
        .o_pop      (pop),
        .i_qchars   (qflat[8*MAX_QUERY-1:0]),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_done     (o_result_valid),
        .o_score    (o_best_score),
        .o_epos     (o_end_position),
        .o_too_long (o_too_long)
    );
endmodule

// ===== rtl/fpms_checker.sv =====
module fpms_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last_char,
    input logic        o_result_valid,
    input logic [9:0]  o_best_score,
    input logic [8:0]  o_end_position,
    input logic        o_too_long
);
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_char |=> busy) else $error("busy not raised");
    a_free_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy && !o_result_valid) else $error("busy after result");
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy) else $error("result while idle");
    a_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_too_long |-> o_best_score == 10'd0 && o_end_position == 9'd0)
        else $error("overflow result not zero");
    a_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_best_score <= 10'd1 |-> o_end_position == 9'd0)
        else $error("position without match");
endmodule

bind fuzzy_path_match_scorer fpms_props u_fpms_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last_char    (i_last_char),
    .o_result_valid (o_result_valid),
    .o_best_score   (o_best_score),
    .o_end_position (o_end_position),
    .o_too_long     (o_too_long)
);
